[design/assert_macros.svh]
// concurrent assertion helpers, clocked on clk and disabled during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ASSERT_IMP(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) \
		else $error(msg);

`else

`define ASSERT_IMP(lbl, ant, cons, msg)
`define ASSERT_NEXT(lbl, ant, cons, msg)

`endif

`endif

[design/spsi_pkg.sv]
package spsi_pkg;

	// page geometry
	localparam int PAGE_BYTES  = 8192;
	localparam int MAX_SLOTS   = 1024;
	localparam int MAX_COLUMNS = 4;

	localparam int SLOT_W  = $clog2(MAX_SLOTS);
	localparam int COUNT_W = $clog2(MAX_SLOTS + 1);
	localparam int WORD_W  = 64;
	localparam int REC_COLS = 4;
	localparam int REC_W   = WORD_W * REC_COLS;
	localparam int COL_W   = 3;

	// page size in 8-byte units
	localparam int PAGE_UNITS = PAGE_BYTES / 8;
	localparam int PU_W       = $clog2(PAGE_UNITS + 1);
	localparam int UNIT_W     = (COUNT_W + 3 > PU_W) ? COUNT_W + 3 : PU_W;

	// configuration port
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	typedef logic [REC_W-1:0] rec_t;

	// operation codes
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_READ   = 1'b1;

	// status codes
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_RANGE = 2'd2;

	// register indexes
	localparam logic REG_LEAF_MODE    = 1'b0;
	localparam logic REG_COLUMN_COUNT = 1'b1;

	// clamp column count into 1..MAX_COLUMNS
	function automatic logic [COL_W-1:0] cols_used(input logic [COL_W-1:0] c);
		logic [COL_W-1:0] r;
		r = c;
		if (r == '0) r = COL_W'(1);
		if (r > COL_W'(MAX_COLUMNS)) r = COL_W'(MAX_COLUMNS);
		return r;
	endfunction

	// columns carried per record in the current mode
	function automatic logic [COL_W-1:0] live_cols(input logic leaf, input logic [COL_W-1:0] c);
		return leaf ? cols_used(c) : COL_W'(2);
	endfunction

	// zero every column at or past n
	function automatic rec_t mask_rec(input rec_t r, input logic [COL_W-1:0] n);
		rec_t m;
		m = r;
		for (int i = 0; i < REC_COLS; i++) begin
			if (COL_W'(i) >= n) m[i*WORD_W +: WORD_W] = '0;
		end
		return m;
	endfunction

	// one more record would reach the page size, or the slots are already at capacity
	function automatic logic page_full_f(input logic [COUNT_W-1:0] cnt, input logic leaf,
			input logic [COL_W-1:0] c);
		logic [UNIT_W-1:0] nxt;
		logic [UNIT_W-1:0] units;
		nxt = UNIT_W'(cnt) + UNIT_W'(1);
		if (leaf) units = nxt * UNIT_W'(cols_used(c));
		else units = nxt << 1;
		return (cnt >= COUNT_W'(MAX_SLOTS)) || (units >= UNIT_W'(PAGE_UNITS));
	endfunction

endpackage

[design/spsi_if.sv]
// request channel
interface spsi_in_if;
	logic                              valid;
	logic                              ready;
	logic                              op;
	logic [spsi_pkg::SLOT_W-1:0]       slot;
	logic signed [spsi_pkg::WORD_W-1:0] key;
	logic signed [spsi_pkg::WORD_W-1:0] field_one;
	logic signed [spsi_pkg::WORD_W-1:0] field_two;
	logic signed [spsi_pkg::WORD_W-1:0] field_three;

	modport source (output valid, op, slot, key, field_one, field_two, field_three,
		input ready);
	modport sink (input valid, op, slot, key, field_one, field_two, field_three,
		output ready);
endinterface

// response channel
interface spsi_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [spsi_pkg::WORD_W-1:0] out_key;
	logic signed [spsi_pkg::WORD_W-1:0] out_one;
	logic signed [spsi_pkg::WORD_W-1:0] out_two;
	logic signed [spsi_pkg::WORD_W-1:0] out_three;
	logic [spsi_pkg::COUNT_W-1:0]      record_count;
	logic                              page_full;
	logic [1:0]                        status;

	modport source (output valid, out_key, out_one, out_two, out_three, record_count,
		page_full, status, input ready);
	modport sink (input valid, out_key, out_one, out_two, out_three, record_count,
		page_full, status, output ready);
endinterface

[design/sorted_page_slot_insert_top.sv]
// sorted page store: one 1024 x 256 record memory, one read and one write per cycle
// read: accept, registered memory read, then the response state; rejected ops go straight to the response state
// insert: records above the new key move up one slot, top first, then the key is written
// one request in work at a time; a finished result waits in an output register
// async reset: count zero, leaf mode, one column; record memory is not cleared
`include "assert_macros.svh"

module sorted_page_slot_insert_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [spsi_pkg::APB_AW-1:0]     paddr,
	input  logic [spsi_pkg::APB_DW-1:0]     pwdata,
	output logic [spsi_pkg::APB_DW-1:0]     prdata,
	output logic                            pready,
	spsi_in_if.sink                         in_ch,
	spsi_out_if.source                      out_ch
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SHIFT  = 3'd1;
	localparam logic [2:0] ST_PLACE  = 3'd2;
	localparam logic [2:0] ST_RDWAIT = 3'd3;
	localparam logic [2:0] ST_RESP   = 3'd4;

	localparam int SW = spsi_pkg::SLOT_W;
	localparam int CW = spsi_pkg::COUNT_W;

	logic [2:0]                   state_q;
	logic [CW-1:0]                count_q;
	logic [CW-1:0]                pos_q;
	logic                         leaf_q;
	logic [spsi_pkg::COL_W-1:0]   cols_q;
	spsi_pkg::rec_t               rec_q;
	spsi_pkg::rec_t               res_data_q;
	logic [1:0]                   res_status_q;
	spsi_pkg::rec_t               out_data_q;
	logic [1:0]                   out_status_q;
	logic [CW-1:0]                out_count_q;
	logic                         out_full_q;
	logic                         out_valid_q;

	spsi_pkg::rec_t               record_mem [spsi_pkg::MAX_SLOTS];
	spsi_pkg::rec_t               rd_data_q;

	logic                         in_fire;
	logic                         cfg_wr;
	logic                         full_now;
	logic                         shift_go;
	logic                         resp_load;
	logic [spsi_pkg::COL_W-1:0]   ncols;
	spsi_pkg::rec_t               in_rec;
	logic                         mem_we;
	logic                         mem_re;
	logic [SW-1:0]                waddr;
	logic [SW-1:0]                raddr;
	spsi_pkg::rec_t               wdata;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == spsi_pkg::REG_COLUMN_COUNT) ?
		spsi_pkg::APB_DW'(cols_q) : spsi_pkg::APB_DW'(leaf_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leaf_q <= 1'b1;
			cols_q <= spsi_pkg::COL_W'(1);
		end else if (cfg_wr) begin
			unique case (paddr[2])
				spsi_pkg::REG_LEAF_MODE:    leaf_q <= pwdata[0];
				spsi_pkg::REG_COLUMN_COUNT: cols_q <= pwdata[spsi_pkg::COL_W-1:0];
				default: ;
			endcase
		end
	end

	// request decode
	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_fire     = in_ch.valid && in_ch.ready;
	assign ncols       = spsi_pkg::live_cols(leaf_q, cols_q);
	assign full_now    = spsi_pkg::page_full_f(count_q, leaf_q, cols_q);
	assign in_rec      = spsi_pkg::mask_rec({in_ch.field_three, in_ch.field_two,
		in_ch.field_one, in_ch.key}, ncols);

	// new key goes below the record just read
	assign shift_go = $signed(rec_q[spsi_pkg::WORD_W-1:0]) <=
		$signed(rd_data_q[spsi_pkg::WORD_W-1:0]);

	assign resp_load = (state_q == ST_RESP) && (!out_valid_q || out_ch.ready);

	// memory port control
	always_comb begin
		mem_we = 1'b0;
		mem_re = 1'b0;
		waddr  = pos_q[SW-1:0];
		raddr  = '0;
		wdata  = rec_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					if (in_ch.op == spsi_pkg::OP_INSERT) begin
						if (!full_now && count_q == '0) begin
							mem_we = 1'b1;
							waddr  = '0;
							wdata  = in_rec;
						end else if (!full_now) begin
							mem_re = 1'b1;
							raddr  = SW'(count_q - CW'(1));
						end
					end else if (CW'(in_ch.slot) < count_q) begin
						mem_re = 1'b1;
						raddr  = in_ch.slot;
					end
				end
			end
			ST_SHIFT: begin
				mem_we = 1'b1;
				if (shift_go) begin
					wdata = rd_data_q;
					if (pos_q != CW'(1)) begin
						mem_re = 1'b1;
						raddr  = SW'(pos_q - CW'(2));
					end
				end
			end
			ST_PLACE: begin
				mem_we = 1'b1;
				waddr  = '0;
			end
			default: ;
		endcase
	end

	// record memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) record_mem[waddr] <= wdata;
		if (mem_re) rd_data_q <= record_mem[raddr];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			pos_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (in_ch.op == spsi_pkg::OP_INSERT) begin
							if (full_now) begin
								state_q <= ST_RESP;
							end else if (count_q == '0) begin
								count_q <= count_q + CW'(1);
								state_q <= ST_RESP;
							end else begin
								pos_q   <= count_q;
								state_q <= ST_SHIFT;
							end
						end else if (CW'(in_ch.slot) < count_q) begin
							state_q <= ST_RDWAIT;
						end else begin
							state_q <= ST_RESP;
						end
					end
				end
				ST_SHIFT: begin
					if (shift_go) begin
						pos_q <= pos_q - CW'(1);
						if (pos_q == CW'(1)) state_q <= ST_PLACE;
					end else begin
						count_q <= count_q + CW'(1);
						state_q <= ST_RESP;
					end
				end
				ST_PLACE: begin
					count_q <= count_q + CW'(1);
					state_q <= ST_RESP;
				end
				ST_RDWAIT: state_q <= ST_RESP;
				ST_RESP:   if (resp_load) state_q <= ST_IDLE;
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

	// operation payload and pending result
	always_ff @(posedge clk) begin
		if (in_fire) begin
			rec_q      <= in_rec;
			res_data_q <= '0;
			if (in_ch.op == spsi_pkg::OP_INSERT)
				res_status_q <= full_now ? spsi_pkg::STAT_FULL : spsi_pkg::STAT_OK;
			else
				res_status_q <= (CW'(in_ch.slot) < count_q) ? spsi_pkg::STAT_OK :
					spsi_pkg::STAT_RANGE;
		end
		if (state_q == ST_RDWAIT) res_data_q <= spsi_pkg::mask_rec(rd_data_q, ncols);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (resp_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (resp_load) begin
			out_data_q   <= res_data_q;
			out_status_q <= res_status_q;
			out_count_q  <= count_q;
			out_full_q   <= full_now;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.out_key      = out_data_q[0*spsi_pkg::WORD_W +: spsi_pkg::WORD_W];
	assign out_ch.out_one      = out_data_q[1*spsi_pkg::WORD_W +: spsi_pkg::WORD_W];
	assign out_ch.out_two      = out_data_q[2*spsi_pkg::WORD_W +: spsi_pkg::WORD_W];
	assign out_ch.out_three    = out_data_q[3*spsi_pkg::WORD_W +: spsi_pkg::WORD_W];
	assign out_ch.record_count = out_count_q;
	assign out_ch.page_full    = out_full_q;
	assign out_ch.status       = out_status_q;

	// checks
	`ASSERT_IMP(a_count_cap, 1'b1, count_q <= CW'(spsi_pkg::MAX_SLOTS), "count past capacity")
	`ASSERT_IMP(a_shift_pos, state_q == ST_SHIFT, pos_q != '0 && pos_q <= count_q, "shift slot out of range")
	`ASSERT_NEXT(a_out_src, state_q != ST_RESP && !out_valid_q, !out_valid_q, "result without response state")
	`ASSERT_NEXT(a_count_idle, state_q == ST_IDLE && !in_fire, $stable(count_q), "count moved while idle")

endmodule
